// ----- rtl/rti_pkg.sv -----
// Package for the ray / triangle intersection block.
// Holds the default number format and the configuration register indexes.
// No dependencies.
package rti_pkg;

    localparam int COMPONENT_BITS_DEF = 20;
    localparam int FRACTION_BITS_DEF  = 8;
    localparam int TOL_BITS           = 8;

    typedef enum logic {
        CFG_FACING_TOL = 1'b0,
        CFG_EDGE_TOL   = 1'b1
    } t_cfg_index;

endpackage

// ----- rtl/ray_triangle_intersect.sv -----
// Ray / triangle intersection: plane test, pipelined division for t,
// hit point and a test against each edge of the triangle. Depends on rti_pkg.
//
//  channel   | direction | word contents
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | ray_origin, ray_direction, vertex_a/b/c, face_normal
//  m_axis    | out       | tdata: hit_distance, hit_point; tuser: hit
//  cfg       | in        | register index, 8-bit tolerance value
//
// One word enters per cycle while m_axis does not stall. The pipeline has COMPONENT_BITS + 8
// register stages (28 by default), the number set by the divider with one quotient bit per
// stage.
// Every stage has its own valid bit and advances when its successor frees,
// so bubbles close up and a stall on m_axis loses or repeats nothing.
// Reset clears the valid bits and both tolerances to zero.
module ray_triangle_intersect
    import rti_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // ray_origin, ray_direction, vertex_a, vertex_b, vertex_c, face_normal
    input  logic [((18*COMPONENT_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // hit_distance, hit_point
    output logic [((4*COMPONENT_BITS+7)/8)*8-1:0]  o_m_axis_tdata,
    // hit
    output logic                                   o_m_axis_tuser,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic                                   i_cfg_addr,
    input  logic [TOL_BITS-1:0]                    i_cfg_data
);

    localparam int CB = COMPONENT_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int GW = 18*CB;
    localparam int OW = ((4*CB+7)/8)*8;
    localparam int DW = 2*CB+3;
    localparam int RW = DW+CB+FB;
    localparam int XW = 2*CB+3;
    localparam int MW = XW-FB;
    localparam int EW = MW+CB+2;
    localparam int PS = 2*CB+2;

    localparam int F_ORG = 0;
    localparam int F_DIR = 1;
    localparam int F_VA  = 2;
    localparam int F_N   = 5;

    function automatic logic signed [CB-1:0] comp(input logic [GW-1:0] g,
                                                  input int f, input int k);
        return g[(f*3+k)*CB +: CB];
    endfunction

    logic [TOL_BITS-1:0] r_facing_tol;
    logic [TOL_BITS-1:0] r_edge_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_facing_tol <= '0;
            r_edge_tol   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_FACING_TOL: r_facing_tol <= i_cfg_data;
                CFG_EDGE_TOL:   r_edge_tol   <= i_cfg_data;
                default:        r_facing_tol <= r_facing_tol;
            endcase
        end
    end

    logic en1, en2, en3, en4, en5, en6, en7, en_o;
    logic [CB:0] en_d;

    // Stage 1: plane products.
    logic                  r_v1;
    logic [GW-1:0]         r1_g;
    logic signed [2*CB-1:0] r1_nd [3];
    logic signed [2*CB:0]   r1_no [3];
    logic [GW-1:0]         w_g;

    assign w_g = i_s_axis_tdata[GW-1:0];
    assign en1 = !r_v1 || en2;
    assign o_s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en1) r_v1 <= i_s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_g <= w_g;
            for (int k = 0; k < 3; k++) begin
                r1_nd[k] <= comp(w_g, F_N, k) * comp(w_g, F_DIR, k);
                r1_no[k] <= comp(w_g, F_N, k) *
                    ((CB+1)'(comp(w_g, F_ORG, k)) - (CB+1)'(comp(w_g, F_VA, k)));
            end
        end
    end

    // Stage 2: sums, facing test, divider setup (index 0 of divider arrays).
    logic              r_dv   [CB+1];
    logic [RW-1:0]     r_drem [CB+1];
    logic [DW-1:0]     r_dden [CB+1];
    logic [CB-1:0]     r_dq   [CB+1];
    logic              r_dok  [CB+1];
    logic              r_dsat [CB+1];
    logic [GW-1:0]     r_dg   [CB+1];

    logic signed [DW-1:0] w_d1, w_dist, w_negf;
    logic [DW-1:0]        w_den;

    always_comb begin
        w_d1   = DW'(r1_nd[0]) + DW'(r1_nd[1]) + DW'(r1_nd[2]);
        w_dist = DW'(r1_no[0]) + DW'(r1_no[1]) + DW'(r1_no[2]);
        w_negf = DW'(0) - DW'(r_facing_tol);
        w_den  = DW'(0) - w_d1;
    end

    assign en2 = en_d[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else if (en_d[0]) r_dv[0] <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (en_d[0]) begin
            r_dg[0]   <= r1_g;
            r_dq[0]   <= '0;
            r_dden[0] <= w_den;
            r_drem[0] <= RW'($unsigned(w_dist)) << FB;
            r_dsat[0] <= (RW'($unsigned(w_dist)) << FB) >= (RW'(w_den) << CB);
            r_dok[0]  <= (w_d1 < 0) && (w_d1 <= w_negf) && (w_dist >= 0);
        end
    end

    // Divider: one quotient bit per stage, most significant first.
    for (genvar j = 0; j < CB; j++) begin : g_div
        logic [RW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = RW'(r_dden[j]) << (CB-1-j);
        assign w_ge = r_drem[j] >= w_sh;
        assign en_d[j] = !r_dv[j] || en_d[j+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[j+1] <= 1'b0;
            else if (en_d[j+1]) r_dv[j+1] <= r_dv[j];
        end

        always_ff @(posedge i_clk) begin
            if (en_d[j+1]) begin
                r_dg[j+1]   <= r_dg[j];
                r_dden[j+1] <= r_dden[j];
                r_dok[j+1]  <= r_dok[j];
                r_dsat[j+1] <= r_dsat[j];
                r_drem[j+1] <= w_ge ? r_drem[j] - w_sh : r_drem[j];
                r_dq[j+1]   <= r_dq[j] | (w_ge ? CB'(1) << (CB-1-j) : CB'(0));
            end
        end
    end

    assign en_d[CB] = !r_dv[CB] || en3;

    // Stage 3: saturate t, products t * dir.
    logic                   r_v3, r3_ok;
    logic [CB-1:0]          r3_t;
    logic [GW-1:0]          r3_g;
    logic signed [2*CB:0]   r3_td [3];
    logic [CB-1:0]          w_t;

    assign w_t = r_dsat[CB] ? '1 : r_dq[CB];
    assign en3 = !r_v3 || en4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (en3) r_v3 <= r_dv[CB];
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_t  <= w_t;
            r3_g  <= r_dg[CB];
            r3_ok <= r_dok[CB];
            for (int k = 0; k < 3; k++)
                r3_td[k] <= $signed({1'b0, w_t}) * comp(r_dg[CB], F_DIR, k);
        end
    end

    // Stage 4: hit point with per-component saturation.
    logic                 r_v4, r4_ok;
    logic [CB-1:0]        r4_t;
    logic [GW-1:0]        r4_g;
    logic [3*CB-1:0]      r4_p;
    logic signed [PS-1:0] w_ps [3];
    logic [3*CB-1:0]      w_p;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ps[k] = PS'(comp(r3_g, F_ORG, k)) + PS'(r3_td[k] >>> FB);
            if (w_ps[k][PS-1:CB-1] == '0 || w_ps[k][PS-1:CB-1] == '1)
                w_p[k*CB +: CB] = w_ps[k][CB-1:0];
            else if (w_ps[k][PS-1])
                w_p[k*CB +: CB] = {1'b1, {(CB-1){1'b0}}};
            else
                w_p[k*CB +: CB] = {1'b0, {(CB-1){1'b1}}};
        end
    end

    assign en4 = !r_v4 || en5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (en4) r_v4 <= r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_t  <= r3_t;
            r4_g  <= r3_g;
            r4_ok <= r3_ok;
            r4_p  <= w_p;
        end
    end

    // Stage 5: edge cross-product terms.
    logic                   r_v5, r5_ok;
    logic [CB-1:0]          r5_t;
    logic [GW-1:0]          r5_g;
    logic [3*CB-1:0]        r5_p;
    logic signed [XW-1:0]   r5_pa [3][3];
    logic signed [XW-1:0]   r5_pb [3][3];
    logic signed [CB:0]     w_u [3][3];
    logic signed [CB:0]     w_e [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                w_u[i][k] = (CB+1)'(comp(r4_g, F_VA + i, k)) -
                            (CB+1)'($signed(r4_p[k*CB +: CB]));
                w_e[i][k] = (CB+1)'(comp(r4_g, F_VA + (i + 1) % 3, k)) -
                            (CB+1)'(comp(r4_g, F_VA + i, k));
            end
        end
    end

    assign en5 = !r_v5 || en6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else if (en5) r_v5 <= r_v4;
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_t  <= r4_t;
            r5_g  <= r4_g;
            r5_ok <= r4_ok;
            r5_p  <= r4_p;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r5_pa[i][k] <= w_u[i][(k+1)%3] * w_e[i][(k+2)%3];
                    r5_pb[i][k] <= w_u[i][(k+2)%3] * w_e[i][(k+1)%3];
                end
            end
        end
    end

    // Stage 6: cross-product components floored to the component scale.
    logic                 r_v6, r6_ok;
    logic [CB-1:0]        r6_t;
    logic [GW-1:0]        r6_g;
    logic [3*CB-1:0]      r6_p;
    logic signed [MW-1:0] r6_m [3][3];

    assign en6 = !r_v6 || en7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else if (en6) r_v6 <= r_v5;
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_t  <= r5_t;
            r6_g  <= r5_g;
            r6_ok <= r5_ok;
            r6_p  <= r5_p;
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++)
                    r6_m[i][k] <= MW'((r5_pa[i][k] - r5_pb[i][k]) >>> FB);
        end
    end

    // Stage 7: projection on the normal.
    logic                    r_v7, r7_ok;
    logic [CB-1:0]           r7_t;
    logic [3*CB-1:0]         r7_p;
    logic signed [MW+CB-1:0] r7_mn [3][3];

    assign en7 = !r_v7 || en_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v7 <= 1'b0;
        else if (en7) r_v7 <= r_v6;
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r7_t  <= r6_t;
            r7_ok <= r6_ok;
            r7_p  <= r6_p;
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++)
                    r7_mn[i][k] <= r6_m[i][k] * comp(r6_g, F_N, k);
        end
    end

    // Output stage: edge decisions and result word.
    logic                 r_vo, r_o_hit;
    logic [CB-1:0]        r_o_dist;
    logic [3*CB-1:0]      r_o_point;
    logic signed [EW-1:0] w_es [3];
    logic signed [EW-1:0] w_nege;
    logic                 w_hit;

    always_comb begin
        w_nege = EW'(0) - EW'(r_edge_tol);
        w_hit  = r7_ok;
        for (int i = 0; i < 3; i++) begin
            w_es[i] = EW'(r7_mn[i][0]) + EW'(r7_mn[i][1]) + EW'(r7_mn[i][2]);
            if (w_es[i] < w_nege) w_hit = 1'b0;
        end
    end

    assign en_o = !r_vo || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vo <= 1'b0;
        else if (en_o) r_vo <= r_v7;
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_hit   <= w_hit;
            r_o_dist  <= w_hit ? r7_t : '0;
            r_o_point <= w_hit ? r7_p : '0;
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tuser  = r_o_hit;
    assign o_m_axis_tdata  = OW'({r_o_point, r_o_dist});

endmodule

// ----- verif/ray_triangle_intersect_tb.sv -----
`timescale 1ns / 100ps
// Testbench for ray_triangle_intersect: drives ray/triangle words, predicts hit, distance and
// point in fixed point, and compares every output word in order. Depends on rti_pkg and the DUT.
module ray_triangle_intersect_tb;
    import rti_pkg::*;

    localparam int CB = 20;
    localparam int FB = 8;
    localparam int IN_W = ((18*CB+7)/8)*8;
    localparam int OUT_W = ((4*CB+7)/8)*8;
    localparam longint COMP_MAX = (64'sd1 <<< (CB-1)) - 1;
    localparam longint COMP_MIN = -(64'sd1 <<< (CB-1));
    localparam longint T_MAX = (64'sd1 <<< CB) - 1;
    localparam int LIMIT = 400000;

    typedef struct {
        logic [59:0] org, dir, va, vb, vc, nrm;
    } t_ray_tri;

    typedef struct {
        logic        hit;
        logic [19:0] distance;
        logic [59:0] point;
    } t_hit;

    typedef struct {
        t_ray_tri item;
        logic     known;
        t_hit     res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_s_axis_tvalid;
    logic o_s_axis_tready;
    logic [IN_W-1:0] i_s_axis_tdata;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic o_m_axis_tuser;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_addr;
    logic [TOL_BITS-1:0] i_cfg_data;

    ray_triangle_intersect dut (.*);

    longint unsigned facing_tol, edge_tol;
    t_hit hit_q[$];
    int errors;
    int cycles;
    logic hold_rx;
    logic sender_done;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint comp(logic [59:0] v, int k);
        logic signed [19:0] c;
        c = v[k*CB +: CB];
        return longint'(c);
    endfunction

    function automatic longint floor_shr(longint x);
        return x >>> FB;
    endfunction

    function automatic longint clamp(longint v);
        if (v > COMP_MAX) return COMP_MAX;
        if (v < COMP_MIN) return COMP_MIN;
        return v;
    endfunction

    function automatic longint dotv(longint a[3], longint b[3]);
        return a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
    endfunction

    function automatic bit inside_edge(longint f[3], longint t[3], longint p[3],
                                       longint n[3]);
        longint u[3], e[3], m[3];
        for (int k = 0; k < 3; k++) begin
            u[k] = f[k] - p[k];
            e[k] = t[k] - f[k];
        end
        m[0] = floor_shr(u[1]*e[2] - u[2]*e[1]);
        m[1] = floor_shr(u[2]*e[0] - u[0]*e[2]);
        m[2] = floor_shr(u[0]*e[1] - u[1]*e[0]);
        return dotv(m, n) >= -longint'(edge_tol);
    endfunction

    function automatic t_hit predict(t_ray_tri x);
        longint o[3], d[3], a[3], b[3], c[3], n[3], p[3];
        longint d1, span, t;
        t_hit r;
        r = '{hit: 0, distance: '0, point: '0};
        for (int k = 0; k < 3; k++) begin
            o[k] = comp(x.org, k);
            d[k] = comp(x.dir, k);
            a[k] = comp(x.va, k);
            b[k] = comp(x.vb, k);
            c[k] = comp(x.vc, k);
            n[k] = comp(x.nrm, k);
        end
        d1 = dotv(n, d);
        if (d1 >= 0 || d1 > -longint'(facing_tol)) return r;
        span = dotv(n, o) - dotv(n, a);
        if (span < 0) return r;
        t = longint'(($unsigned(span) << FB) / $unsigned(-d1));
        if (t > T_MAX) t = T_MAX;
        for (int k = 0; k < 3; k++) p[k] = clamp(o[k] + floor_shr(t * d[k]));
        if (!inside_edge(a, b, p, n) || !inside_edge(b, c, p, n) ||
            !inside_edge(c, a, p, n)) return r;
        r.hit = 1;
        r.distance = t[19:0];
        for (int k = 0; k < 3; k++) r.point[k*CB +: CB] = p[k][19:0];
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("Mismatch in %s at cycle %0d: got %h, expected %h", what, cycles, got, want);
        errors++;
    endtask

    function automatic logic [59:0] vec(int x, int y, int z);
        return {20'(z), 20'(y), 20'(x)};
    endfunction

    function automatic logic [59:0] rand_vec(int span);
        return vec($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
                   $urandom_range(0, 2*span) - span);
    endfunction

    // A triangle on the plane z = h with a normal near +z (va sometimes random), and a ray from above aimed down at it.
    function automatic t_ray_tri good_item();
        t_ray_tri x;
        int h, s, n;
        h = $urandom_range(0, 2000) - 1000;
        s = $urandom_range(64, 4000);
        n = $urandom_range(1, 300);
        x.va = vec(-s, -s, h);
        x.vb = vec(s, -s, h);
        x.vc = vec(0, s, h);
        x.nrm = vec($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3, n);
        x.org = vec($urandom_range(0, s) - s/2, $urandom_range(0, s) - s/2,
                    h + $urandom_range(0, 3000));
        x.dir = vec($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
                    -int'($urandom_range(1, 2000)));
        if ($urandom_range(0, 7) == 0) x.va = rand_vec(3000);
        return x;
    endfunction

    function automatic t_ray_tri rand_item();
        t_ray_tri x;
        case ($urandom_range(0, 9))
            0: x = '{60'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                     60'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                     60'({$urandom, $urandom}), 60'({$urandom, $urandom})};
            1, 2: x = '{rand_vec(5000), rand_vec(5000), rand_vec(5000), rand_vec(5000),
                        rand_vec(5000), rand_vec(5000)};
            default: x = good_item();
        endcase
        return x;
    endfunction

    task automatic write_reg(t_cfg_index idx, logic [7:0] val);
        i_cfg_valid <= 1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        if (idx == CFG_FACING_TOL) facing_tol = val;
        else edge_tol = val;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 0;
        while (hit_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // The word stays valid after acceptance; the next call replaces it or opens a gap.
    task automatic send(t_ray_tri x, bit gaps);
        int g;
        if (gaps) begin
            g = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0) g = 0;
            if (g > 0) begin
                i_s_axis_tvalid <= 0;
                repeat (g) @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata <= IN_W'({x.nrm, x.vc, x.vb, x.va, x.dir, x.org});
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        hit_q.push_back(predict(x));
    endtask

    t_row rows[$];

    initial begin
        t_ray_tri base;
        t_hit miss;
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_cfg_valid = 0;
        i_cfg_addr = 0;
        i_cfg_data = '0;
        facing_tol = 0;
        edge_tol = 0;
        sender_done = 0;
        hold_rx = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        miss = '{hit: 0, distance: '0, point: '0};
        base.va = vec(-256, -256, 0);
        base.vb = vec(256, -256, 0);
        base.vc = vec(0, 256, 0);
        base.nrm = vec(0, 0, 256);
        base.org = vec(0, 0, 512);
        base.dir = vec(0, 0, -256);
        rows.push_back('{base, 1, '{1, 20'd512, vec(0, 0, 0)}});
        rows.push_back('{'{base.org, vec(256, 0, 0), base.va, base.vb, base.vc, base.nrm},
                         1, miss});
        rows.push_back('{'{base.org, vec(0, 0, 256), base.va, base.vb, base.vc, base.nrm},
                         1, miss});
        rows.push_back('{'{vec(0, 0, -512), base.dir, base.va, base.vb, base.vc, base.nrm},
                         1, miss});
        rows.push_back('{'{vec(5000, 0, 512), base.dir, base.va, base.vb, base.vc,
                           base.nrm}, 1, miss});
        rows.push_back('{'{vec(0, 0, 'h7FFFF), vec(0, 0, -1), base.va, base.vb, base.vc,
                           base.nrm}, 0, miss});
        rows.push_back('{'{vec(0, 0, 'h7FFFF), vec('h7FFFF, 'h80000, -1), base.va, base.vb,
                           base.vc, base.nrm}, 0, miss});
        rows.push_back('{'{vec(0, 0, 0), base.dir, base.va, base.vb, base.vc, base.nrm},
                         0, miss});
        rows.push_back('{'{vec(-256, -256, 10), base.dir, base.va, base.vb, base.vc,
                           base.nrm}, 0, miss});
        rows.push_back('{'{'0, '0, '0, '0, '0, '0}, 1, miss});
        rows.push_back('{'{'1, '1, '1, '1, '1, '1}, 0, miss});
        rows.push_back('{'{{3{20'h80000}}, {3{20'h7FFFF}}, {3{20'h80000}}, {3{20'h7FFFF}},
                           {3{20'h80000}}, {3{20'h7FFFF}}}, 0, miss});
        rows.push_back('{'{{3{20'h7FFFF}}, {3{20'h80000}}, {3{20'h7FFFF}}, {3{20'h80000}},
                           {3{20'h7FFFF}}, {3{20'h80000}}}, 0, miss});
        rows.push_back('{'{{3{20'h7FFFF}}, {3{20'h80000}}, {3{20'h80000}}, {3{20'h7FFFF}},
                           {3{20'h80000}}, {3{20'h7FFFF}}}, 0, miss});
        foreach (rows[i]) begin
            send(rows[i].item, 0);
            if (rows[i].known && hit_q[$] != rows[i].res) begin
                report("directed row", i, 0);
            end
        end
        drain();

        // Small-normal rays near the tolerance edges, with both tolerances at the maximum setting.
        write_reg(CFG_FACING_TOL, 8'd255);
        write_reg(CFG_EDGE_TOL, 8'd255);
        send('{base.org, vec(0, 0, -1), base.va, base.vb, base.vc, vec(0, 0, 255)}, 0);
        send('{base.org, vec(0, 0, -1), base.va, base.vb, base.vc, vec(0, 0, 256)}, 0);
        send('{vec(-257, -256, 512), base.dir, base.va, base.vb, base.vc, base.nrm}, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_FACING_TOL, 0); write_reg(CFG_EDGE_TOL, 0); end
                1: begin write_reg(CFG_FACING_TOL, 255); write_reg(CFG_EDGE_TOL, 255); end
                default: begin
                    write_reg(CFG_FACING_TOL, $urandom_range(0, 255));
                    write_reg(CFG_EDGE_TOL, $urandom_range(0, 255));
                end
            endcase
            if (ph == 3) hold_rx = 1;
            for (int i = 0; i < 250; i++) begin
                send(rand_item(), ph != 3);
                if (ph == 4 && i == 100) drain();
            end
            drain();
        end
        sender_done = 1;
    end

    // Receiver stalls; one long hold-off while the sender keeps feeding words.
    initial begin
        int g;
        bit held;
        held = 0;
        i_m_axis_tready = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_rx && !held) begin
                i_m_axis_tready <= 0;
                repeat (399) @(posedge i_clk);
                held = 1;
            end else if ($urandom_range(0, 3) == 0) begin
                g = ($urandom_range(0, 10) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
                i_m_axis_tready <= 0;
                repeat (g - 1) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (hit_q.size() == 0) begin
                report("unexpected word", o_m_axis_tdata[63:0], 0);
            end else begin
                want = hit_q.pop_front();
                if (o_m_axis_tuser !== want.hit) report("hit", o_m_axis_tuser, want.hit);
                if (o_m_axis_tdata[19:0] !== want.distance)
                    report("hit_distance", o_m_axis_tdata[19:0], want.distance);
                if (o_m_axis_tdata[79:20] !== want.point)
                    report("hit_point", o_m_axis_tdata[79:20], want.point);
            end
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (sender_done) begin
                if (errors == 0) $display("All tests passed");
                else $display("Some tests failed");
                $finish;
            end else if (cycles > LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
